FILE: hw/rtl/modinv_pkg.sv
// Package with shared constants and the sequencer state type of the modular inverse block.
`timescale 1ns / 1ps

package modinv_pkg;

    // Width of the signed base operand.
    localparam int BASE_WIDTH = 64;

    // Default modulus width.
    localparam int MOD_WIDTH_DEF = 31;

    // Step counter width; it must reach BASE_WIDTH - 1.
    localparam int CNT_W = $clog2(BASE_WIDTH);

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REDUCE = 6'b000010,
        S_FIX    = 6'b000100,
        S_NEXT   = 6'b001000,
        S_MUL    = 6'b010000,
        S_SQR    = 6'b100000
    } t_state;

endpackage

FILE: hw/rtl/modular_inverse_fermat_top.sv
// Modular inverse by Fermat exponentiation on one shared bit-serial modular multiply-add unit.
// An item with modulus below 2 gives its result in the cycle after it is accepted.
// Otherwise the base is reduced and sign-fixed, then raised to modulus - 2: for each exponent bit,
// LSB first, a set bit multiplies the accumulator by the base power, and the power is squared.
// Throughput: one item at a time; the next item is taken at the edge that ends the result cycle.
// Reset (synchronous, active low) returns the sequencer to idle and clears the result strobe.
`timescale 1ns / 1ps

module modular_inverse_fermat_top
    import modinv_pkg::*;
#(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [BASE_WIDTH-1:0]   i_base,
    input  logic [MOD_WIDTH-1:0]    i_modulus,
    output logic                    o_valid,
    output logic [MOD_WIDTH-1:0]    o_inverse
);

    // Bit index over the exponent must be able to hold MOD_WIDTH itself.
    localparam int BIDX_W = $clog2(MOD_WIDTH + 1);
    localparam int PAD_W  = BASE_WIDTH - MOD_WIDTH;

    // Sequencer.
    t_state r_state;
    t_state n_state;

    // Operands and working registers of the shared unit.
    logic [MOD_WIDTH-1:0]  r_m;        // modulus of the item in flight
    logic                  r_neg;      // base was negative
    logic [BASE_WIDTH-1:0] r_sh;       // multiplier bits, consumed from the top
    logic [MOD_WIDTH-1:0]  r_t;        // running partial result of the unit
    logic [CNT_W-1:0]      r_cnt;      // step counter within one pass
    logic [MOD_WIDTH-1:0]  r_x;        // current power of the base
    logic [MOD_WIDTH-1:0]  r_acc;      // exponentiation accumulator
    logic [MOD_WIDTH-1:0]  r_e;        // remaining exponent bits, LSB first
    logic [BIDX_W-1:0]     r_bidx;     // exponent bit index
    logic                  r_valid;
    logic [MOD_WIDTH-1:0]  r_inverse;

    // Shared unit signals.
    logic                  s_bit;
    logic [MOD_WIDTH-1:0]  s_add;
    logic [MOD_WIDTH+1:0]  s_t;
    logic [MOD_WIDTH+1:0]  s_m;
    logic [MOD_WIDTH+1:0]  s_two_m;
    logic [MOD_WIDTH-1:0]  s_red;
    logic [BASE_WIDTH-1:0] s_mag;
    logic                  s_accept;
    logic                  s_small;

    assign busy     = (r_state != S_IDLE);
    assign s_accept = start && !busy;
    // A modulus of 0 or 1 has no exponentiation; the answer is 0.
    assign s_small  = (i_modulus < MOD_WIDTH'(2));

    // Magnitude of the signed base; the most negative value maps to 2^63 unsigned.
    assign s_mag = i_base[BASE_WIDTH-1] ? (~i_base + BASE_WIDTH'(1)) : i_base;

    // The shared unit computes t' = (2*t + bit*addend) mod m in one step. Since t < m and
    // addend < m, the sum stays below 3*m, so one of two parallel subtractions reduces it.
    // Reduction of the base uses an addend of 1, which makes each step a restoring
    // remainder step; multiplication uses the multiplicand as addend, MSB first.
    assign s_bit   = r_sh[BASE_WIDTH-1];
    assign s_add   = (r_state == S_REDUCE) ? MOD_WIDTH'(1) : r_x;
    assign s_t     = {1'b0, r_t, 1'b0} + {2'b00, (s_add & {MOD_WIDTH{s_bit}})};
    assign s_m     = {2'b00, r_m};
    assign s_two_m = {1'b0, r_m, 1'b0};

    always_comb begin
        if (s_t >= s_two_m) begin
            s_red = MOD_WIDTH'(s_t - s_two_m);
        end else if (s_t >= s_m) begin
            s_red = MOD_WIDTH'(s_t - s_m);
        end else begin
            s_red = MOD_WIDTH'(s_t);
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept && !s_small) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (r_cnt == CNT_W'(BASE_WIDTH - 1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (r_bidx == BIDX_W'(MOD_WIDTH)) begin
                    n_state = S_IDLE;
                end else if (r_e[0]) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(MOD_WIDTH - 1)) begin
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                if (r_cnt == CNT_W'(MOD_WIDTH - 1)) begin
                    n_state = S_NEXT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (s_accept && s_small) ||
                       ((r_state == S_NEXT) && (r_bidx == BIDX_W'(MOD_WIDTH)));
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    r_m     <= i_modulus;
                    r_neg   <= i_base[BASE_WIDTH-1];
                    r_sh    <= s_mag;
                    r_t     <= '0;
                    r_cnt   <= '0;
                end
                if (s_accept && s_small) begin
                    r_inverse <= '0;
                end
            end
            S_REDUCE: begin
                r_t   <= s_red;
                r_sh  <= {r_sh[BASE_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_FIX: begin
                // A negative base with a nonzero remainder maps to m minus that remainder.
                r_x    <= (r_neg && (r_t != '0)) ? (r_m - r_t) : r_t;
                r_acc  <= MOD_WIDTH'(1);
                r_e    <= r_m - MOD_WIDTH'(2);
                r_bidx <= '0;
            end
            S_NEXT: begin
                r_t   <= '0;
                r_cnt <= '0;
                if (r_bidx == BIDX_W'(MOD_WIDTH)) begin
                    r_inverse <= r_acc;
                end else if (r_e[0]) begin
                    r_sh <= {r_acc, {PAD_W{1'b0}}};
                end else begin
                    r_sh <= {r_x, {PAD_W{1'b0}}};
                end
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(MOD_WIDTH - 1)) begin
                    // Product acc * x is done; set up the square of x.
                    r_acc <= s_red;
                    r_t   <= '0;
                    r_cnt <= '0;
                    r_sh  <= {r_x, {PAD_W{1'b0}}};
                end else begin
                    r_t   <= s_red;
                    r_sh  <= {r_sh[BASE_WIDTH-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            S_SQR: begin
                if (r_cnt == CNT_W'(MOD_WIDTH - 1)) begin
                    r_x    <= s_red;
                    r_e    <= {1'b0, r_e[MOD_WIDTH-1:1]};
                    r_bidx <= r_bidx + BIDX_W'(1);
                end else begin
                    r_t   <= s_red;
                    r_sh  <= {r_sh[BASE_WIDTH-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            default: begin
                r_t <= '0;
            end
        endcase
    end

    assign o_valid   = r_valid;
    assign o_inverse = r_inverse;

    // The partial result of the shared unit stays reduced while it is in use.
    a_t_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_REDUCE) || (r_state == S_MUL) || (r_state == S_SQR)) |-> (r_t < r_m))
        else $error("partial result not below modulus");

    // The base power and the accumulator stay reduced during exponentiation.
    a_x_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_NEXT) || (r_state == S_MUL) || (r_state == S_SQR)) |->
        ((r_x < r_m) && (r_acc < r_m)))
        else $error("exponentiation operands not below modulus");

    // A result is only strobed with the sequencer back at idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobed while busy");

    // An accepted item with a usable modulus always starts the sequencer.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !s_small) |=> busy)
        else $error("accepted item did not start the sequencer");

endmodule
